FILE: hw/rtl/sliding_window_median_cost_macros.svh
// assertion helpers for the sliding window median block
`ifndef SLIDING_WINDOW_MEDIAN_COST_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_COST_MACROS_SVH

// implication checked in the same cycle
`define SWMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define SWMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/swmc_pkg.sv
package swmc_pkg;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int COST_W = 39;
  localparam int CFG_W = 7;

  // default window depth and derived widths
  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam int INDEX_W_DEFAULT = $clog2(WINDOW_MAX_DEFAULT);
  localparam int ACC_W_DEFAULT = COST_W + 1;

  // window size after reset
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                       vld;
    logic                       gt;
    logic signed [SAMPLE_W-1:0] val;
  } swmc_link_t;

  // broadcast command to every cell
  typedef struct packed {
    logic                       clr;
    logic                       ins;
    logic                       del;
    logic signed [SAMPLE_W-1:0] key;
  } swmc_cmd_t;

endpackage

FILE: hw/rtl/swmc_cell.sv
module swmc_cell #(
  parameter int CELL_INDEX = 0,
  parameter int INDEX_W = swmc_pkg::INDEX_W_DEFAULT,
  parameter int ACC_W = swmc_pkg::ACC_W_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  swmc_pkg::swmc_cmd_t                 cmd,
  input  swmc_pkg::swmc_link_t                from_left,
  input  swmc_pkg::swmc_link_t                from_right,
  output swmc_pkg::swmc_link_t                link,
  input  logic [INDEX_W-1:0]                  mid_index,
  input  logic signed [ACC_W-1:0]             acc_in,
  output logic signed [ACC_W-1:0]             acc_out,
  input  logic signed [swmc_pkg::SAMPLE_W-1:0] med_in,
  output logic signed [swmc_pkg::SAMPLE_W-1:0] med_out
);
  import swmc_pkg::*;

  logic signed [SAMPLE_W-1:0] val;
  logic signed [SAMPLE_W-1:0] val_next;
  logic                       vld;
  logic                       vld_next;
  logic                       gt;
  logic                       ge;
  logic                       is_upper;
  logic                       is_mid;
  logic signed [ACC_W-1:0]    val_ext;
  logic signed [ACC_W-1:0]    contrib;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] med;

  // compare against the broadcast key
  assign gt = vld && (val > cmd.key);
  assign ge = vld && (val >= cmd.key);

  assign link.vld = vld;
  assign link.gt  = gt;
  assign link.val = val;

  // insert shifts the larger tail right, delete pulls the tail left
  always_comb begin
    val_next = val;
    vld_next = vld;
    if (cmd.clr) begin
      vld_next = 1'b0;
    end else if (cmd.ins) begin
      if (from_left.gt) begin
        val_next = from_left.val;
        vld_next = 1'b1;
      end else if (gt || (!vld && from_left.vld)) begin
        val_next = cmd.key;
        vld_next = 1'b1;
      end
    end else if (cmd.del && ge) begin
      val_next = from_right.val;
      vld_next = from_right.vld;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  // stored sample
  always_ff @(posedge clk) begin
    val <= val_next;
  end

  // signed partial sum: samples below the median count negative
  assign is_upper = (mid_index <= INDEX_W'(CELL_INDEX));
  assign is_mid   = (mid_index == INDEX_W'(CELL_INDEX));
  assign val_ext  = ACC_W'(val);
  assign contrib  = !vld ? '0 : (is_upper ? val_ext : -val_ext);

  always_ff @(posedge clk) begin
    acc <= acc_in + contrib;
    med <= is_mid ? val : med_in;
  end

  assign acc_out = acc;
  assign med_out = med;

endmodule

FILE: hw/rtl/sliding_window_median_cost.sv
// Sliding window median: keeps the last window_size samples (clamped to 1..WINDOW_MAX) in a
// sorted row of cells plus an arrival-order ring memory. Each accepted item may first restart
// the window, then the oldest samples are dropped while the window is full, then the sample
// is inserted. When the window becomes full, one result follows with the lower median and the
// sum of absolute deviations from it, and the oldest sample is dropped. An item that gives no
// result passes the check and insert states before the next accept; an item with a result
// also waits for the partial sum running down the cell row one cell per cycle, and for the
// output register to be free. Every sample dropped because the window was made smaller
// adds a ring read and a cell shift. No clearing pass after reset is needed.
`include "sliding_window_median_cost_macros.svh"

module sliding_window_median_cost #(
  parameter int WINDOW_MAX = swmc_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [swmc_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [swmc_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [swmc_pkg::SAMPLE_W-1:0] median,
  output logic [swmc_pkg::COST_W-1:0]          cost
);
  import swmc_pkg::*;

  localparam int IW = $clog2(WINDOW_MAX);
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int OW = FW + 1;
  localparam int SUM_W = SAMPLE_W + FW + 1;
  localparam int ACC_W = (SUM_W > COST_W) ? SUM_W : COST_W + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_DROP   = 7'b0000100,
    S_INSERT = 7'b0001000,
    S_SUM    = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_TAIL   = 7'b1000000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [CFG_W-1:0]           window_size;
  logic [FW-1:0]              keff;
  logic [IW-1:0]              mid_index;
  logic [FW-1:0]              fill;
  logic [IW-1:0]              wp;
  logic [IW-1:0]              cnt;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] ring_q;
  logic                       ring_rd;
  logic [OW-1:0]              back;
  logic [IW-1:0]              oldest;
  logic                       in_accept;
  logic                       out_free;
  logic                       emit;
  swmc_cmd_t                  cmd;
  swmc_link_t                 head_link;
  swmc_link_t                 tail_link;
  swmc_link_t                 link [WINDOW_MAX];
  logic signed [ACC_W-1:0]    acc [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] med [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      vld_vec;
  logic signed [ACC_W-1:0]    med_ext;
  logic signed [ACC_W-1:0]    total;

  // window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  // clamp to 1..WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      keff = FW'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      keff = FW'(WINDOW_MAX);
    end else begin
      keff = FW'(window_size);
    end
  end

  assign mid_index = IW'((keff - FW'(1)) >> 1);

  // handshake
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit      = (state == S_FINISH) && out_free;

  // ring slot of the oldest sample
  always_comb begin
    back = OW'(wp) + OW'(WINDOW_MAX) - OW'(fill);
    if (back >= OW'(WINDOW_MAX)) begin
      oldest = IW'(back - OW'(WINDOW_MAX));
    end else begin
      oldest = IW'(back);
    end
  end

  assign ring_rd = (state == S_CHECK) || emit;

  // arrival ring memory
  always_ff @(posedge clk) begin
    if (state == S_INSERT) begin
      ring[wp] <= sample_q;
    end
    if (ring_rd) begin
      ring_q <= ring[oldest];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = (fill >= keff) ? S_DROP : S_INSERT;
      end
      S_DROP: begin
        state_next = S_CHECK;
      end
      S_INSERT: begin
        state_next = ((fill + FW'(1)) == keff) ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        if (cnt == IW'(WINDOW_MAX - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      wp    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (in_accept && restart) begin
        fill <= '0;
        wp   <= '0;
      end else if (state == S_DROP || state == S_TAIL) begin
        fill <= fill - FW'(1);
      end else if (state == S_INSERT) begin
        fill <= fill + FW'(1);
        wp   <= (wp == IW'(WINDOW_MAX - 1)) ? '0 : wp + IW'(1);
      end
      if (state == S_INSERT) begin
        cnt <= '0;
      end else if (state == S_SUM) begin
        cnt <= cnt + IW'(1);
      end
    end
  end

  // accepted sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q <= sample;
    end
  end

  // cell row command
  always_comb begin
    cmd.clr = in_accept && restart;
    cmd.ins = (state == S_INSERT);
    cmd.del = (state == S_DROP) || (state == S_TAIL);
    cmd.key = cmd.ins ? sample_q : ring_q;
  end

  assign head_link = '{vld: 1'b1, gt: 1'b0, val: '0};
  assign tail_link = '{vld: 1'b0, gt: 1'b0, val: '0};

  // sorted row of cells
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swmc_link_t                 from_left;
    swmc_link_t                 from_right;
    logic signed [ACC_W-1:0]    acc_in;
    logic signed [SAMPLE_W-1:0] med_in;

    if (i == 0) begin : g_head
      assign from_left = head_link;
      assign acc_in    = '0;
      assign med_in    = '0;
    end else begin : g_body
      assign from_left = link[i-1];
      assign acc_in    = acc[i-1];
      assign med_in    = med[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign from_right = tail_link;
    end else begin : g_inner
      assign from_right = link[i+1];
    end

    swmc_cell #(
      .CELL_INDEX (i),
      .INDEX_W    (IW),
      .ACC_W      (ACC_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .from_left  (from_left),
      .from_right (from_right),
      .link       (link[i]),
      .mid_index  (mid_index),
      .acc_in     (acc_in),
      .acc_out    (acc[i]),
      .med_in     (med_in),
      .med_out    (med[i])
    );

    assign vld_vec[i] = link[i].vld;
  end

  // cost from the signed sum: odd window subtracts the median once, even twice
  assign med_ext = ACC_W'(med[WINDOW_MAX-1]);
  assign total   = acc[WINDOW_MAX-1] - (keff[0] ? med_ext : (med_ext <<< 1));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      median <= med[WINDOW_MAX-1];
      cost   <= total[COST_W-1:0];
    end
  end

  // checks
  `SWMC_ASSERT_IMP(a_cells_match_fill, 1'b1, $countones(vld_vec) == int'(fill), "cell count mismatch")
  `SWMC_ASSERT_IMP(a_room_on_insert, state == S_INSERT, fill < keff, "insert into full window")
  `SWMC_ASSERT_NXT(a_finish_loads, (state == S_FINISH) && !out_valid, out_valid, "result not loaded")

endmodule
